// ===== rtl/core/nss_pkg.sv =====
// Shared types and constants for the nearest station search block.
package nss_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned DIST_W    = 40;
  localparam int unsigned AXIS_W    = 20;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned SQ_W      = 2 * AXIS_W;
  localparam int unsigned SUM_W     = SQ_W + 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned LIST_DEPTH_DEFAULT = 4096;

  // One axis may differ by less than 10000 m.
  localparam logic [DIFF_W-1:0] AXIS_LIMIT    = DIFF_W'(1000000);
  // Running minimum starts at (10000 m)^2 in square centimetres.
  localparam logic [DIST_W-1:0] DIST_SQ_LIMIT = DIST_W'(64'd1000000000000);
  // Only ids above this value qualify.
  localparam logic [ID_W-1:0]   MIN_ID        = ID_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_NORTHING   = 3'd0,
    REG_REF_EASTING    = 3'd1,
    REG_REF_ALTITUDE   = 3'd2,
    REG_GROUND_MODE    = 3'd3,
    REG_EXCLUDE_ENABLE = 3'd4,
    REG_EXCLUDE_ID     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]           cand_id;
    logic signed [COORD_W-1:0] cand_northing;
    logic signed [COORD_W-1:0] cand_easting;
    logic signed [COORD_W-1:0] cand_altitude;
    logic                      last;
  } cand_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   best_id;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0] best_dist_sq;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ref_northing;
    logic signed [COORD_W-1:0] ref_easting;
    logic signed [COORD_W-1:0] ref_altitude;
    logic                      ground_mode;
    logic                      exclude_enable;
    logic [ID_W-1:0]           exclude_id;
  } cfg_t;

  // Candidate after the axis difference stage.
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic              last;
    logic              in_range;
    logic [AXIS_W-1:0] mag_n;
    logic [AXIS_W-1:0] mag_e;
    logic [AXIS_W-1:0] mag_a;
  } diff_stage_t;

  // Candidate after the squaring stage.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            last;
    logic            in_range;
    logic [SQ_W-1:0] sq_n;
    logic [SQ_W-1:0] sq_e;
    logic [SQ_W-1:0] sq_a;
  } sq_stage_t;

endpackage

// ===== rtl/core/nearest_station_search.sv =====
// Nearest station search: a candidate is taken on every cycle of an open input.
// A last candidate's result is registered after the input, diff and square stages.
// Throughput: one candidate per cycle through input, difference, square and
// compare stages; the input stalls only while a last candidate reaches the compare
// stage and the result register still holds an untaken result.
// Synchronous reset (rst) clears the config, search state and all valid bits.
module nearest_station_search #(
  parameter int unsigned LIST_DEPTH = nss_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cand_valid,
  output logic                              cand_stall,
  input  nss_pkg::cand_t                    cand,
  output logic                              res_valid,
  input  logic                              res_stall,
  output nss_pkg::result_t                  res,
  input  logic                              cfg_write,
  input  logic [nss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nss_pkg::COORD_W-1:0]       cfg_data
);
  import nss_pkg::*;

  cfg_t        cfg;
  logic        hold;
  logic        advance;
  logic        in_valid;
  cand_t       in_reg;
  diff_stage_t s1;
  sq_stage_t   s2;

  assign advance    = !hold;
  assign cand_stall = hold;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_NORTHING:   cfg.ref_northing   <= cfg_data;
        REG_REF_EASTING:    cfg.ref_easting    <= cfg_data;
        REG_REF_ALTITUDE:   cfg.ref_altitude   <= cfg_data;
        REG_GROUND_MODE:    cfg.ground_mode    <= cfg_data[0];
        REG_EXCLUDE_ENABLE: cfg.exclude_enable <= cfg_data[0];
        REG_EXCLUDE_ID:     cfg.exclude_id     <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: captures a candidate on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_reg <= cand;
    end
  end

  nss_diff u_diff (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .cand_in_valid (in_valid),
    .cand_in       (in_reg),
    .cfg           (cfg),
    .s1            (s1)
  );

  nss_square u_square (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .s1      (s1),
    .s2      (s2)
  );

  nss_select #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .s2        (s2),
    .cfg       (cfg),
    .hold      (hold),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== rtl/core/nss_diff.sv =====
// Axis difference stage: magnitudes of the axis differences and the range check.
module nss_diff (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 cand_in_valid,
  input  nss_pkg::cand_t       cand_in,
  input  nss_pkg::cfg_t        cfg,
  output nss_pkg::diff_stage_t s1
);
  import nss_pkg::*;

  logic [DIFF_W-1:0] diff_n, diff_e, diff_a;
  logic [DIFF_W-1:0] abs_n, abs_e, abs_a;
  logic              ok_n, ok_e, ok_a;

  // Signed differences, one bit wider than the coordinates.
  always_comb begin
    diff_n = {cfg.ref_northing[COORD_W-1], cfg.ref_northing}
           - {cand_in.cand_northing[COORD_W-1], cand_in.cand_northing};
    diff_e = {cfg.ref_easting[COORD_W-1], cfg.ref_easting}
           - {cand_in.cand_easting[COORD_W-1], cand_in.cand_easting};
    diff_a = {cfg.ref_altitude[COORD_W-1], cfg.ref_altitude}
           - {cand_in.cand_altitude[COORD_W-1], cand_in.cand_altitude};
  end

  // Magnitudes and range check; ground mode drops the altitude axis.
  always_comb begin
    abs_n = diff_n[DIFF_W-1] ? (~diff_n + 1'b1) : diff_n;
    abs_e = diff_e[DIFF_W-1] ? (~diff_e + 1'b1) : diff_e;
    abs_a = diff_a[DIFF_W-1] ? (~diff_a + 1'b1) : diff_a;
    ok_n  = abs_n < AXIS_LIMIT;
    ok_e  = abs_e < AXIS_LIMIT;
    ok_a  = cfg.ground_mode || (abs_a < AXIS_LIMIT);
  end

  // Stage register: the valid bit is reset, the payload only follows transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= cand_in_valid;
    end
    if (advance) begin
      s1.id       <= cand_in.cand_id;
      s1.last     <= cand_in.last;
      s1.in_range <= ok_n && ok_e && ok_a;
      s1.mag_n    <= abs_n[AXIS_W-1:0];
      s1.mag_e    <= abs_e[AXIS_W-1:0];
      s1.mag_a    <= cfg.ground_mode ? '0 : abs_a[AXIS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/nss_square.sv =====
// Squaring stage: one multiplier per axis.
module nss_square (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  nss_pkg::diff_stage_t s1,
  output nss_pkg::sq_stage_t   s2
);
  import nss_pkg::*;

  logic [SQ_W-1:0] sq_n, sq_e, sq_a;

  // Squares of the axis magnitudes.
  always_comb begin
    sq_n = s1.mag_n * s1.mag_n;
    sq_e = s1.mag_e * s1.mag_e;
    sq_a = s1.mag_a * s1.mag_a;
  end

  // Stage register: the valid bit is reset, the payload only follows transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (advance) begin
      s2.valid <= s1.valid;
    end
    if (advance) begin
      s2.id       <= s1.id;
      s2.last     <= s1.last;
      s2.in_range <= s1.in_range;
      s2.sq_n     <= sq_n;
      s2.sq_e     <= sq_e;
      s2.sq_a     <= sq_a;
    end
  end

endmodule

// ===== rtl/core/nss_select.sv =====
// Running minimum over the list, list position counter and result register.
module nss_select #(
  parameter int unsigned LIST_DEPTH = nss_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  nss_pkg::sq_stage_t s2,
  input  nss_pkg::cfg_t      cfg,
  output logic               hold,
  output logic               res_valid,
  input  logic               res_stall,
  output nss_pkg::result_t   res
);
  import nss_pkg::*;

  localparam int unsigned POS_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [DIST_W-1:0]  min_dist_sq;
  logic [ID_W-1:0]    winner_id;
  logic [INDEX_W-1:0] winner_index;
  logic               have_winner;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   position_next;
  logic [INDEX_W-1:0] pos_index;

  logic [SUM_W-1:0]   dist_sum;
  logic               qualify;
  logic               commit;
  logic               win_found;
  logic [ID_W-1:0]    win_id;
  logic [INDEX_W-1:0] win_index;
  logic [DIST_W-1:0]  win_dist;

  // Reported index is the list position, cut or zero-extended to INDEX_W bits.
  if (POS_W >= INDEX_W) begin : g_pos_trunc
    assign pos_index = position[INDEX_W-1:0];
  end else begin : g_pos_ext
    assign pos_index = {{(INDEX_W - POS_W){1'b0}}, position};
  end

  assign position_next = (position == POS_W'(LIST_DEPTH - 1)) ? '0 : position + 1'b1;

  // A last candidate waits while the result register holds an untaken result.
  assign hold   = res_valid && res_stall && s2.valid && s2.last;
  assign commit = s2.valid && !hold;

  // Distance sum and the qualification test against the running minimum.
  always_comb begin
    dist_sum = SUM_W'(s2.sq_n) + SUM_W'(s2.sq_e) + SUM_W'(s2.sq_a);
    qualify  = s2.in_range && (s2.id > MIN_ID)
            && !(cfg.exclude_enable && (s2.id == cfg.exclude_id))
            && (dist_sum < SUM_W'(min_dist_sq));
  end

  // Winner including the candidate now in this stage.
  always_comb begin
    win_found = have_winner || qualify;
    win_id    = qualify ? s2.id : winner_id;
    win_index = qualify ? pos_index : winner_index;
    win_dist  = qualify ? dist_sum[DIST_W-1:0] : min_dist_sq;
  end

  // Search state: updated per candidate, cleared after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist_sq  <= DIST_SQ_LIMIT;
      winner_id    <= '0;
      winner_index <= '0;
      have_winner  <= 1'b0;
      position     <= '0;
    end else if (commit) begin
      if (s2.last) begin
        min_dist_sq  <= DIST_SQ_LIMIT;
        winner_id    <= '0;
        winner_index <= '0;
        have_winner  <= 1'b0;
        position     <= '0;
      end else begin
        min_dist_sq  <= win_dist;
        winner_id    <= win_id;
        winner_index <= win_index;
        have_winner  <= win_found;
        position     <= position_next;
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit && s2.last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload; fields read zero when nothing qualified.
  always_ff @(posedge clk) begin
    if (commit && s2.last) begin
      res.found        <= win_found;
      res.best_id      <= win_found ? win_id : '0;
      res.best_index   <= win_found ? win_index : '0;
      res.best_dist_sq <= win_found ? win_dist : '0;
    end
  end

  a_hold_keeps_state: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(min_dist_sq) && $stable(position))
    else $error("search state changed while a last candidate was held");

  a_idle_minimum: assert property (@(posedge clk) disable iff (rst)
    !have_winner |-> (min_dist_sq == DIST_SQ_LIMIT) && (winner_id == '0))
    else $error("running minimum moved without a winner");

  a_winner_bounds: assert property (@(posedge clk) disable iff (rst)
    have_winner |-> (min_dist_sq < DIST_SQ_LIMIT) && (winner_id > MIN_ID))
    else $error("winner outside the qualifying range");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.found |-> (res.best_id == '0) && (res.best_dist_sq == '0))
    else $error("result without a winner carries nonzero fields");

endmodule

// ===== verif/tb_nearest_station_search.sv =====
// Self-checking testbench for the nearest station search block.
module tb_nearest_station_search;
  timeunit 1ns;
  timeprecision 1ps;

  import nss_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned BLOCK_ITEMS    = 75;
  localparam int unsigned NUM_BLOCKS     = 12;

  localparam longint            AXIS_LIMIT_CM = 1000000;
  localparam logic [63:0]       DIST_CAP      = 64'd1000000000000;
  localparam logic [ID_W-1:0]   ID_FLOOR      = 16'd10;
  localparam result_t           NO_WIN        = '0;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum bit {ROW_CAND, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [COORD_W-1:0]     reg_data;
    cand_t                  c;
    bit                     known;
    result_t                res;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cand_valid = 1'b0;
  logic                 cand_stall;
  cand_t                cand       = '0;
  logic                 res_valid;
  logic                 res_stall  = 1'b0;
  result_t              res;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [COORD_W-1:0]   cfg_data   = '0;

  // A typed-in result travels beside the candidate that closes its list.
  bit      cand_known     = 1'b0;
  result_t cand_known_res = '0;

  int unsigned send_idle_pct  = 25;
  int unsigned recv_stall_pct = 83;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned errors         = 0;
  int unsigned quiet_cycles   = 0;

  result_t expected_winners[$];

  // Register copy used by the predictor.
  logic signed [COORD_W-1:0] site_n = '0;
  logic signed [COORD_W-1:0] site_e = '0;
  logic signed [COORD_W-1:0] site_a = '0;
  bit                        ground_only = 1'b0;
  bit                        skip_en     = 1'b0;
  logic [ID_W-1:0]           skip_id     = '0;

  // Running search state of the predictor.
  logic [63:0]        best_sq  = DIST_CAP;
  logic [ID_W-1:0]    best_id  = '0;
  logic [INDEX_W-1:0] best_idx = '0;
  logic [INDEX_W-1:0] list_pos = '0;
  bit                 have_best = 1'b0;

  nearest_station_search u_dut (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic result_t win(logic [ID_W-1:0] id, logic [INDEX_W-1:0] idx,
                                  logic [DIST_W-1:0] sq);
    result_t r;
    r.found        = 1'b1;
    r.best_id      = id;
    r.best_index   = idx;
    r.best_dist_sq = sq;
    return r;
  endfunction

  function void clear_search();
    best_sq   = DIST_CAP;
    best_id   = '0;
    best_idx  = '0;
    list_pos  = '0;
    have_best = 1'b0;
  endfunction

  function void mirror_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    case (idx)
      REG_REF_NORTHING:   site_n = data;
      REG_REF_EASTING:    site_e = data;
      REG_REF_ALTITUDE:   site_a = data;
      REG_GROUND_MODE:    ground_only = data[0];
      REG_EXCLUDE_ENABLE: skip_en = data[0];
      REG_EXCLUDE_ID:     skip_id = data[ID_W-1:0];
      default: ;
    endcase
  endfunction

  // Folds one candidate into the running minimum; returns 1 when the list closes.
  function automatic bit search_step(input cand_t c, output result_t r);
    longint      diff [3];
    longint      mag;
    logic [63:0] sum;
    bit          in_range;
    int          axes;
    diff[0]  = longint'(site_n) - longint'($signed(c.cand_northing));
    diff[1]  = longint'(site_e) - longint'($signed(c.cand_easting));
    diff[2]  = longint'(site_a) - longint'($signed(c.cand_altitude));
    axes     = ground_only ? 2 : 3;
    in_range = 1'b1;
    sum      = '0;
    for (int k = 0; k < axes; k++) begin
      mag = (diff[k] < 0) ? -diff[k] : diff[k];
      if (mag >= AXIS_LIMIT_CM) in_range = 1'b0;
      else sum += 64'(mag * mag);
    end
    // Strictly below keeps the earlier candidate on a tie.
    if (in_range && c.cand_id > ID_FLOOR && !(skip_en && c.cand_id == skip_id) &&
        sum < best_sq) begin
      best_sq   = sum;
      best_id   = c.cand_id;
      best_idx  = list_pos;
      have_best = 1'b1;
    end
    list_pos = list_pos + 1'b1;
    r = NO_WIN;
    if (!c.last) return 1'b0;
    if (have_best) r = win(best_id, best_idx, best_sq[DIST_W-1:0]);
    clear_search();
    return 1'b1;
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Input and output transfers, prediction, checking and the watchdog.
  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    quiet_cycles++;
    if (!rst && cand_valid && !cand_stall) begin
      quiet_cycles = 0;
      if (search_step(cand, predicted))
        expected_winners.push_back(cand_known ? cand_known_res : predicted);
    end
    if (!rst && res_valid && !res_stall) begin
      quiet_cycles = 0;
      if (expected_winners.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, got 0x%0h", $time, res);
        errors++;
      end else begin
        want = expected_winners.pop_front();
        check_field("found", 64'(want.found), 64'(res.found));
        check_field("best_id", 64'(want.best_id), 64'(res.best_id));
        check_field("best_index", 64'(want.best_index), 64'(res.best_index));
        check_field("best_dist_sq", 64'(want.best_dist_sq), 64'(res.best_dist_sq));
      end
    end
    if (cfg_write) quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      res_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    mirror_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Offers one candidate and returns on the falling edge after its transfer.
  task automatic send_cand(cand_t c, bit known, result_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cand_valid = 1'b0;
      @(negedge clk);
    end
    cand           = c;
    cand_known     = known;
    cand_known_res = r;
    cand_valid     = 1'b1;
    @(posedge clk);
    while (cand_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived and the pipeline is empty.
  task automatic settle();
    cand_valid = 1'b0;
    while (expected_winners.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic stim_row_t cand_row(logic [ID_W-1:0] id, logic [COORD_W-1:0] n,
                                         logic [COORD_W-1:0] e, logic [COORD_W-1:0] a,
                                         bit last, bit known, result_t r);
    stim_row_t row;
    row.kind            = ROW_CAND;
    row.reg_idx         = '0;
    row.reg_data        = '0;
    row.c.cand_id       = id;
    row.c.cand_northing = n;
    row.c.cand_easting  = e;
    row.c.cand_altitude = a;
    row.c.last          = last;
    row.known           = known;
    row.res             = r;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    stim_row_t row;
    row.kind     = ROW_CFG;
    row.reg_idx  = idx;
    row.reg_data = data;
    row.c        = '0;
    row.known    = 1'b0;
    row.res      = NO_WIN;
    return row;
  endfunction

  // Mostly close to the reference, sometimes at the range edge, sometimes anywhere.
  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] base);
    int unsigned cls;
    int unsigned mag;
    cls = $urandom_range(0, 99);
    if (cls < 8) return $urandom;
    if (cls < 40) mag = $urandom_range(0, 8);
    else if (cls < 88) mag = $urandom_range(0, 580000);
    else mag = $urandom_range(990000, 1010000);
    return $urandom_range(0, 1) ? base - mag : base + mag;
  endfunction

  function automatic cand_t make_cand(bit last);
    cand_t       c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) c.cand_id = 16'($urandom_range(11, 40));
    else if (pick < 75) c.cand_id = skip_id;
    else if (pick < 85) c.cand_id = 16'($urandom_range(0, 10));
    else c.cand_id = 16'($urandom);
    c.cand_northing = near_coord(site_n);
    c.cand_easting  = near_coord(site_e);
    c.cand_altitude = near_coord(site_a);
    c.last          = last;
    return c;
  endfunction

  // One random block: new register settings, then lists of candidates.
  task automatic run_block(int unsigned blk);
    logic [COORD_W-1:0] base [3];
    int unsigned        items;
    int unsigned        len;
    for (int k = 0; k < 3; k++) begin
      case ((blk + k) % 4)
        0: base[k] = $urandom;
        1: base[k] = 32'h7FFF_FFFF - $urandom_range(0, 400000);
        2: base[k] = 32'h8000_0000 + $urandom_range(0, 400000);
        default: base[k] = 32'($urandom_range(0, 2000)) - 32'd1000;
      endcase
    end
    settle();
    write_reg(REG_REF_NORTHING, base[0]);
    write_reg(REG_REF_EASTING, base[1]);
    write_reg(REG_REF_ALTITUDE, base[2]);
    write_reg(REG_GROUND_MODE, {31'($urandom), 1'(blk % 3 == 1)});
    write_reg(REG_EXCLUDE_ENABLE, {31'($urandom), 1'(blk % 2)});
    if (blk == 5) write_reg(REG_EXCLUDE_ID, {16'($urandom), 16'hFFFF});
    else if (blk == 7) write_reg(REG_EXCLUDE_ID, 32'd0);
    else write_reg(REG_EXCLUDE_ID, {16'($urandom), 16'($urandom_range(11, 40))});
    write_reg(REG_SPARE_7, $urandom);

    if (blk < 4) begin
      send_idle_pct  = 25;
      recv_stall_pct = 83;
    end else if (blk < 8) begin
      send_idle_pct  = 83;
      recv_stall_pct = 25;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end

    // Hold the result side off while lists keep coming, so the input backs up.
    if (blk == 9) hold_req = 1'b1;

    items = 0;
    while (items < BLOCK_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int j = 0; j < len; j++)
        send_cand(make_cand(j == len - 1), 1'b0, NO_WIN);
      items += len;
      // Pause the input once mid-block until the outputs catch up.
      if (blk == 6 && items == len) begin
        cand_valid = 1'b0;
        while (expected_winners.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    stim_row_t dir_rows[$];
    bit        prev_cand;

    clear_search();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Registers still hold their reset values at first.
    dir_rows.push_back(cand_row(16'd5, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, NO_WIN));
    dir_rows.push_back(cand_row(16'd11, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1,
                                win(16'd11, 12'd0, 40'd0)));
    dir_rows.push_back(cfg_row(REG_EXCLUDE_ENABLE, 32'd1));
    dir_rows.push_back(cfg_row(REG_EXCLUDE_ID, 32'd20));
    dir_rows.push_back(cfg_row(REG_SPARE_6, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_SPARE_7, 32'hFFFF_FFFF));
    // Excluded id and an id at the floor, then a winner just inside range.
    dir_rows.push_back(cand_row(16'd20, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd10, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd11, 32'd999999, 32'd0, 32'd0, 1'b1, 1'b1,
                                win(16'd11, 12'd2, 40'd999998000001)));
    // Each axis at exactly the range limit, then all axes far out of range.
    dir_rows.push_back(cand_row(16'd12, 32'd1000000, 32'd0, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd13, 32'd0, -32'sd1000000, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd14, 32'd0, 32'd0, 32'd1000000, 1'b1, 1'b1, NO_WIN));
    dir_rows.push_back(cand_row(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                1'b1, 1'b1, NO_WIN));
    // Every axis in range but the sum beyond the threshold.
    dir_rows.push_back(cand_row(16'd40, 32'd999999, 32'd999999, 32'd999999, 1'b1, 1'b1,
                                NO_WIN));
    // Equal distances: the first one stays.
    dir_rows.push_back(cand_row(16'd30, 32'd3, 32'd4, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd31, 32'd0, 32'd4, 32'd3, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd32, 32'd0, 32'd0, 32'd5, 1'b1, 1'b1,
                                win(16'd30, 12'd0, 40'd25)));
    dir_rows.push_back(cand_row(16'd33, -32'sd7, 32'd0, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'd34, 32'd0, -32'sd2, 32'd0, 1'b1, 1'b0, NO_WIN));
    // Ground distance with the reference at the coordinate extremes.
    dir_rows.push_back(cfg_row(REG_GROUND_MODE, 32'd1));
    dir_rows.push_back(cfg_row(REG_EXCLUDE_ENABLE, 32'd0));
    dir_rows.push_back(cfg_row(REG_REF_NORTHING, 32'h7FFF_FFFF));
    dir_rows.push_back(cfg_row(REG_REF_EASTING, 32'h8000_0000));
    dir_rows.push_back(cfg_row(REG_REF_ALTITUDE, 32'd0));
    dir_rows.push_back(cfg_row(REG_SPARE_6, 32'h0));
    dir_rows.push_back(cand_row(16'd20, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                1'b1, 1'b1, win(16'd20, 12'd0, 40'd0)));
    dir_rows.push_back(cand_row(16'hFFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0000,
                                1'b1, 1'b1, win(16'hFFFF, 12'd0, 40'd1)));
    dir_rows.push_back(cand_row(16'd50, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b1, 1'b1,
                                NO_WIN));
    dir_rows.push_back(cand_row(16'd51, 32'h7FF0_BDC0, 32'h800F_423F, 32'd0, 1'b0, 1'b0,
                                NO_WIN));
    dir_rows.push_back(cand_row(16'd52, 32'h7FFF_FFFF, 32'h8000_03E8, 32'h1234_5678,
                                1'b1, 1'b1, win(16'd52, 12'd1, 40'd1000000)));
    // Exclusion of the highest id.
    dir_rows.push_back(cfg_row(REG_GROUND_MODE, 32'd0));
    dir_rows.push_back(cfg_row(REG_EXCLUDE_ENABLE, 32'd1));
    dir_rows.push_back(cfg_row(REG_EXCLUDE_ID, 32'hFFFF));
    dir_rows.push_back(cfg_row(REG_REF_NORTHING, 32'd0));
    dir_rows.push_back(cfg_row(REG_REF_EASTING, 32'd0));
    dir_rows.push_back(cand_row(16'hFFFF, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, NO_WIN));
    dir_rows.push_back(cand_row(16'hFFFE, 32'd1, 32'd1, 32'd1, 1'b1, 1'b1,
                                win(16'hFFFE, 12'd1, 40'd3)));

    prev_cand = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (prev_cand) settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
        prev_cand = 1'b0;
      end else begin
        send_cand(dir_rows[i].c, dir_rows[i].known, dir_rows[i].res);
        prev_cand = 1'b1;
      end
    end
    cand_known = 1'b0;

    // Random part.
    for (int unsigned blk = 0; blk < NUM_BLOCKS; blk++)
      run_block(blk);

    settle();
    if (errors == 0 && expected_winners.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== nearest_station_search.f =====
rtl/core/nss_pkg.sv
rtl/core/nss_diff.sv
rtl/core/nss_square.sv
rtl/core/nss_select.sv
rtl/core/nearest_station_search.sv
verif/tb_nearest_station_search.sv
